[src/sfd_pkg.sv]
// Shared types and constants for the serial frame deframer.
`default_nettype none

package sfd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned CSR_IDX_W = 2;

   // frame status codes
   localparam logic [STATUS_W-1:0] STATUS_NONE        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_GOOD        = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SUM     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TRAILER = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LENGTH  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAILER_FIRST = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAILER_LAST  = 2'd3;

   // register reset values
   localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h12;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h34;
   localparam logic [BYTE_W-1:0] TRAILER_FIRST_RST = 8'h1F;
   localparam logic [BYTE_W-1:0] TRAILER_LAST_RST  = 8'h2F;

   localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] position;
      logic [BYTE_W-1:0] frame_length;
      logic [BYTE_W-1:0] prev_byte_one;
      logic [BYTE_W-1:0] prev_byte_two;
      logic [BYTE_W-1:0] running_sum;
      logic [BYTE_W-1:0] checksum_seen;
   } sfd_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
      logic [BYTE_W-1:0] trailer_first;
      logic [BYTE_W-1:0] trailer_last;
   } sfd_cfg_type;

   typedef struct packed {
      logic                byte_stored;
      logic [BYTE_W-1:0]   frame_index;
      logic [BYTE_W-1:0]   data_byte;
      logic                frame_done;
      logic [STATUS_W-1:0] frame_status;
   } sfd_result_type;

endpackage

`default_nettype wire

[src/serial_frame_deframer.sv]
// Top level of the serial frame deframer: state, config and result registers.
`default_nettype none

// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_rx_byte[7:0]
// rsp      out        rsp_valid/rsp_stall   rsp_byte_stored, rsp_frame_index[7:0],
//                                           rsp_data_byte[7:0], rsp_frame_done,
//                                           rsp_frame_status[2:0]
// csr      in         csr_write_enable      csr_index[1:0], csr_data[7:0]
//
// One byte beat in, one registered result beat out; one beat per cycle while rsp_stall does not hold the output.
// The parser step is a single pass of compares and an 8-bit add from the
// frame state into the result register.
// Reset (synchronous) empties the hunt window and loads the default header
// and trailer bytes.
// A stalled result holds in the output register and stalls req in turn.

module serial_frame_deframer
   import sfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // byte input
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BYTE_W-1:0]     req_rx_byte,
   // result output
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_byte_stored,
   output logic [BYTE_W-1:0]          rsp_frame_index,
   output logic [BYTE_W-1:0]          rsp_data_byte,
   output logic                       rsp_frame_done,
   output logic [STATUS_W-1:0]        rsp_frame_status,
   // register writes
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [BYTE_W-1:0]     csr_data
);

   sfd_state_type  state_ff, state_in;
   sfd_cfg_type    cfg_ff;
   sfd_result_type result_ff, result_in;
   logic           rsp_valid_ff;
   logic           req_accept;

   // output slot frees when it is empty or being taken this cycle
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   sfd_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .rx_byte   (req_rx_byte),
      .nxt_state (state_in),
      .result    (result_in)
   );

   // frame state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   // header and trailer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= HEADER_FIRST_RST;
         cfg_ff.header_second <= HEADER_SECOND_RST;
         cfg_ff.trailer_first <= TRAILER_FIRST_RST;
         cfg_ff.trailer_last  <= TRAILER_LAST_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HEADER_FIRST:  cfg_ff.header_first  <= csr_data;
            CSR_HEADER_SECOND: cfg_ff.header_second <= csr_data;
            CSR_TRAILER_FIRST: cfg_ff.trailer_first <= csr_data;
            CSR_TRAILER_LAST:  cfg_ff.trailer_last  <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_stored  = result_ff.byte_stored;
   assign rsp_frame_index  = result_ff.frame_index;
   assign rsp_data_byte    = result_ff.data_byte;
   assign rsp_frame_done   = result_ff.frame_done;
   assign rsp_frame_status = result_ff.frame_status;

`ifndef SYNTHESIS
   // a frame end always leaves an empty hunt window
   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      req_accept && result_in.frame_done |=> state_ff.position == 8'd0)
      else $error("frame end did not restart hunting");

   // status only on a frame-ending beat
   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_frame_status == STATUS_NONE)
      else $error("status without frame end");

   // an unstored byte carries index zero and always ends the attempt
   a_unstored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_stored |-> rsp_frame_index == 8'd0 && rsp_frame_done)
      else $error("unstored byte with index or without end");

   // a result accepted with no new byte leaves the slot empty
   a_slot_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !req_valid |=> !rsp_valid)
      else $error("result repeated");
`endif

endmodule

`default_nettype wire

[src/sfd_step.sv]
// Per-byte parser step: next frame state and result beat from current state.
`default_nettype none

module sfd_step
   import sfd_pkg::*;
(
   input  sfd_state_type      cur_state,
   input  sfd_cfg_type        cfg,
   input  logic [BYTE_W-1:0]  rx_byte,
   output sfd_state_type      nxt_state,
   output sfd_result_type     result
);

   logic [BYTE_W-1:0] ck_len;   // checksum index from the length byte
   logic [BYTE_W-1:0] ck_cur;   // checksum index from the stored length
   logic [BYTE_W-1:0] pos_inc;
   sfd_state_type     empty_state;

   assign ck_len  = rx_byte - 8'd3;
   assign ck_cur  = cur_state.frame_length - 8'd3;
   assign pos_inc = cur_state.position + 8'd1;
   assign empty_state = '0;

   always_comb begin
      nxt_state           = cur_state;
      result.byte_stored  = 1'b1;
      result.frame_index  = '0;
      result.data_byte    = rx_byte;
      result.frame_done   = 1'b0;
      result.frame_status = STATUS_NONE;

      case (cur_state.position)
         8'd0: begin
            nxt_state.prev_byte_two = rx_byte;
            nxt_state.position      = 8'd1;
         end
         8'd1: begin
            nxt_state.prev_byte_one = rx_byte;
            nxt_state.position      = 8'd2;
            result.frame_index      = 8'd1;
         end
         8'd2: begin
            if (cur_state.prev_byte_two != cfg.header_first ||
                cur_state.prev_byte_one != cfg.header_second) begin
               // slide the hunt window
               nxt_state.prev_byte_two = cur_state.prev_byte_one;
               nxt_state.prev_byte_one = rx_byte;
               result.frame_index      = 8'd1;
            end else if (rx_byte < MIN_LENGTH) begin
               nxt_state           = empty_state;
               result.frame_index  = 8'd2;
               result.frame_done   = 1'b1;
               result.frame_status = STATUS_BAD_LENGTH;
            end else begin
               nxt_state.running_sum   = '0;
               nxt_state.checksum_seen = '0;
               if (ck_len > 8'd2) begin
                  nxt_state.running_sum = rx_byte;
               end else if (ck_len == 8'd2) begin
                  nxt_state.checksum_seen = rx_byte;   // length five
               end else begin
                  nxt_state.checksum_seen = cur_state.prev_byte_one; // length four
               end
               nxt_state.frame_length  = rx_byte;
               nxt_state.prev_byte_one = rx_byte;
               nxt_state.position      = 8'd3;
               result.frame_index      = 8'd2;
            end
         end
         default: begin
            if (cur_state.position >= cur_state.frame_length ||
                cur_state.frame_length < MIN_LENGTH) begin
               nxt_state           = empty_state;
               result.byte_stored  = 1'b0;
               result.frame_done   = 1'b1;
               result.frame_status = STATUS_BAD_LENGTH;
            end else if (pos_inc == cur_state.frame_length) begin
               nxt_state          = empty_state;
               result.frame_index = cur_state.position;
               result.frame_done  = 1'b1;
               if (cur_state.prev_byte_one != cfg.trailer_first ||
                   rx_byte != cfg.trailer_last) begin
                  result.frame_status = STATUS_BAD_TRAILER;
               end else if (cur_state.checksum_seen != cur_state.running_sum) begin
                  result.frame_status = STATUS_BAD_SUM;
               end else begin
                  result.frame_status = STATUS_GOOD;
               end
            end else begin
               if (cur_state.position < ck_cur) begin
                  nxt_state.running_sum = cur_state.running_sum + rx_byte;
               end else if (cur_state.position == ck_cur) begin
                  nxt_state.checksum_seen = rx_byte;
               end
               nxt_state.prev_byte_one = rx_byte;
               nxt_state.position      = pos_inc;
               result.frame_index      = cur_state.position;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

[tb/serial_frame_deframer_test.sv]
// Self-checking testbench for the serial frame deframer: byte stream in, checked result beats out.
`timescale 1ns / 100ps

module serial_frame_deframer_test
   import sfd_pkg::*;
();

   // Run-away guard.
   localparam int unsigned CYCLE_LIMIT = 300000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_byte_stored;
   logic [BYTE_W-1:0]     rsp_frame_index;
   logic [BYTE_W-1:0]     rsp_data_byte;
   logic                  rsp_frame_done;
   logic [STATUS_W-1:0]   rsp_frame_status;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [BYTE_W-1:0]     csr_data;

   // Shadow of the parser: its own copy of the frame state and of the registers.
   sfd_state_type  parse_st;
   sfd_cfg_type    link_cfg;
   sfd_result_type expected_beats [$];

   int unsigned mismatch_count = 0;
   int unsigned bytes_sent     = 0;
   int unsigned cycles_run     = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   int unsigned hold_off_left  = 0;

   serial_frame_deframer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_stored  (rsp_byte_stored),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_status (rsp_frame_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Parser shadow. One call per accepted byte beat; returns the result
   // beat the block must produce for it and advances the shadow state.
   // ---------------------------------------------------------------------
   function automatic sfd_result_type deframe_byte(input logic [BYTE_W-1:0] rx);
      sfd_result_type    beat;
      logic [BYTE_W-1:0] sum_pos;
      beat.byte_stored  = 1'b1;
      beat.frame_index  = parse_st.position;
      beat.data_byte    = rx;
      beat.frame_done   = 1'b0;
      beat.frame_status = STATUS_NONE;
      case (parse_st.position)
         8'd0: begin
            // window filling, first slot
            parse_st.prev_byte_two = rx;
            parse_st.position      = 8'd1;
         end
         8'd1: begin
            parse_st.prev_byte_one = rx;
            parse_st.position      = 8'd2;
         end
         8'd2: begin
            if (parse_st.prev_byte_two != link_cfg.header_first ||
                parse_st.prev_byte_one != link_cfg.header_second) begin
               // no header yet: slide the window, new byte lands at index 1
               parse_st.prev_byte_two = parse_st.prev_byte_one;
               parse_st.prev_byte_one = rx;
               beat.frame_index       = 8'd1;
            end else if (rx < MIN_LENGTH) begin
               // short length: reject and hunt again from an empty window
               parse_st          = '0;
               beat.frame_done   = 1'b1;
               beat.frame_status = STATUS_BAD_LENGTH;
            end else begin
               sum_pos                = rx - 8'd3;
               parse_st.running_sum   = '0;
               parse_st.checksum_seen = '0;
               // length byte is summed only when the checksum sits past it;
               // for length five it is the checksum, for four it is index 1
               if (sum_pos > 8'd2)
                  parse_st.running_sum = rx;
               else if (sum_pos == 8'd2)
                  parse_st.checksum_seen = rx;
               else
                  parse_st.checksum_seen = parse_st.prev_byte_one;
               parse_st.frame_length  = rx;
               parse_st.prev_byte_one = rx;
               parse_st.position      = 8'd3;
            end
         end
         default: begin
            if (parse_st.position >= parse_st.frame_length ||
                parse_st.frame_length < MIN_LENGTH) begin
               parse_st          = '0;
               beat.byte_stored  = 1'b0;
               beat.frame_index  = '0;
               beat.frame_done   = 1'b1;
               beat.frame_status = STATUS_BAD_LENGTH;
            end else if (parse_st.position + 8'd1 == parse_st.frame_length) begin
               // last byte: trailer is judged before the checksum
               beat.frame_done = 1'b1;
               if (parse_st.prev_byte_one != link_cfg.trailer_first ||
                   rx != link_cfg.trailer_last)
                  beat.frame_status = STATUS_BAD_TRAILER;
               else if (parse_st.checksum_seen != parse_st.running_sum)
                  beat.frame_status = STATUS_BAD_SUM;
               else
                  beat.frame_status = STATUS_GOOD;
               parse_st = '0;
            end else begin
               if (parse_st.position < parse_st.frame_length - 8'd3)
                  parse_st.running_sum = parse_st.running_sum + rx;
               else if (parse_st.position == parse_st.frame_length - 8'd3)
                  parse_st.checksum_seen = rx;
               parse_st.prev_byte_one = rx;
               parse_st.position      = parse_st.position + 8'd1;
            end
         end
      endcase
      return beat;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: stall pattern plus optional long hold-off, driven at the
   // falling edge; beats are checked at the rising edge they are taken.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_off_left != 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      sfd_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing outstanding: data_byte %0d", rsp_data_byte);
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            check_field("byte_stored",  want.byte_stored,  rsp_byte_stored);
            check_field("frame_index",  want.frame_index,  rsp_frame_index);
            check_field("data_byte",    want.data_byte,    rsp_data_byte);
            check_field("frame_done",   want.frame_done,   rsp_frame_done);
            check_field("frame_status", want.frame_status, rsp_frame_status);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Byte side. Called at a falling edge, returns at a falling edge; valid
   // stays up between back-to-back beats and the byte holds while stalled.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_beats.push_back(deframe_byte(rx));
      bytes_sent++;
      @(negedge clock);
   endtask

   // Header, length, body, checksum, trailer under the current registers.
   // Lengths below four stop after the length byte; keep truncates the frame.
   task automatic send_frame(input int unsigned len, input bit bad_sum,
                             input bit bad_trailer, input int unsigned keep);
      logic [BYTE_W-1:0] frame_bytes [$];
      logic [BYTE_W-1:0] csum;
      logic [BYTE_W-1:0] next_byte;
      int unsigned       sum_pos;
      int unsigned       hit_pos;
      frame_bytes = {link_cfg.header_first, link_cfg.header_second, 8'(len)};
      if (len >= MIN_LENGTH) begin
         sum_pos = len - 3;
         csum    = (sum_pos > 2) ? 8'(len) : 8'h00;
         // length four has no room for the first trailer byte past the length
         hit_pos = (len - 2 >= 3 && $urandom_range(1)) ? len - 2 : len - 1;
         for (int unsigned i = 3; i < len; i++) begin
            if (i == len - 1)
               next_byte = link_cfg.trailer_last;
            else if (i == len - 2)
               next_byte = link_cfg.trailer_first;
            else if (i == sum_pos)
               next_byte = csum ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00);
            else
               next_byte = 8'($urandom);
            if (bad_trailer && i == hit_pos)
               next_byte = next_byte ^ 8'($urandom_range(1, 255));
            if (i < sum_pos)
               csum = csum + next_byte;
            frame_bytes.push_back(next_byte);
         end
      end
      foreach (frame_bytes[i])
         if (i < keep) send_byte(frame_bytes[i]);
   endtask

   // Drop valid, let every outstanding beat drain, then allow the latency.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= val;
      @(negedge clock);
      case (idx)
         CSR_HEADER_FIRST:  link_cfg.header_first  = val;
         CSR_HEADER_SECOND: link_cfg.header_second = val;
         CSR_TRAILER_FIRST: link_cfg.trailer_first = val;
         CSR_TRAILER_LAST:  link_cfg.trailer_last  = val;
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [BYTE_W-1:0] h_first, input logic [BYTE_W-1:0] h_second,
                               input logic [BYTE_W-1:0] t_first, input logic [BYTE_W-1:0] t_last);
      wait_idle();
      write_reg(CSR_HEADER_FIRST,  h_first);
      write_reg(CSR_HEADER_SECOND, h_second);
      write_reg(CSR_TRAILER_FIRST, t_first);
      write_reg(CSR_TRAILER_LAST,  t_last);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly short lengths, a few long ones, some below the minimum.
   function automatic int unsigned pick_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5)
         return $urandom_range(3);
      else if (roll < 8)
         return $urandom_range(21, 254);
      return $urandom_range(4, 20);
   endfunction

   // Well-formed frames with random bodies, seasoned with noise bursts,
   // bad checksums, bad trailers and truncated frames.
   task automatic run_random_traffic(input int unsigned n_items);
      int unsigned start_count;
      int unsigned len;
      int unsigned keep;
      start_count = bytes_sent;
      while (bytes_sent - start_count < n_items) begin
         if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            len  = pick_length();
            keep = ($urandom_range(99) < 8) ? $urandom_range(1, len) : 256;
            send_frame(len, $urandom_range(99) < 20, $urandom_range(99) < 15, keep);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset registers: noise, short length, good, bad sum, bad trailer over
   // bad sum, and length five where the checksum is the length byte.
   task automatic test_directed_frames();
      send_byte(8'hFF);
      send_frame(0, 1'b0, 1'b0, 256);
      send_frame(6, 1'b0, 1'b0, 256);
      send_frame(6, 1'b1, 1'b0, 256);
      send_frame(6, 1'b1, 1'b1, 256);
      send_frame(5, 1'b0, 1'b0, 256);
   endtask

   task automatic test_traffic_sender_idle();
      apply_config(8'h00, 8'hFF, 8'hFF, 8'h00);
      send_idle_pct = 37;
      recv_idle_pct = 70;
      run_random_traffic(450);
   endtask

   // Second header byte zero and first trailer four lets a length-four
   // frame come out good.
   task automatic test_traffic_receiver_idle();
      apply_config(8'hFF, 8'h00, 8'h04, 8'hFF);
      send_idle_pct = 70;
      recv_idle_pct = 37;
      send_frame(4, 1'b0, 1'b0, 256);
      send_frame(4, 1'b0, 1'b1, 256);
      run_random_traffic(450);
   endtask

   task automatic test_traffic_full_rate();
      apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_frame(255, 1'b0, 1'b0, 256);
      run_random_traffic(200);
   endtask

   // Receiver holds off for a long stretch while bytes keep coming, so the
   // output register fills and req is stalled back.
   task automatic test_result_hold_off();
      apply_config(HEADER_FIRST_RST, HEADER_SECOND_RST, TRAILER_FIRST_RST, TRAILER_LAST_RST);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_off_left = 400;
      @(negedge clock);
      run_random_traffic(60);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rx_byte      = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_HEADER_FIRST;
      csr_data         = '0;
      parse_st         = '0;
      link_cfg.header_first  = HEADER_FIRST_RST;
      link_cfg.header_second = HEADER_SECOND_RST;
      link_cfg.trailer_first = TRAILER_FIRST_RST;
      link_cfg.trailer_last  = TRAILER_LAST_RST;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_frames();
      test_traffic_sender_idle();
      test_traffic_receiver_idle();
      test_traffic_full_rate();
      test_result_hold_off();

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[files.f]
src/sfd_pkg.sv
src/sfd_step.sv
src/serial_frame_deframer.sv
tb/serial_frame_deframer_test.sv
